// File: src/sqvs_pkg.sv
// ----------------------------------------------------------------------------
// sqvs_pkg
// Shared constants for the square voice synthesizer and its divider.
// ----------------------------------------------------------------------------
package sqvs_pkg;

   localparam int VOICES     = 8;
   localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int VCNT_W     = $clog2(VOICES + 1);

   localparam int RATE_W     = 18;
   localparam logic [RATE_W-1:0] RATE_MIN   = 18'd200;
   localparam logic [RATE_W-1:0] RATE_MAX   = 18'd200000;
   localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

   localparam int DIV_NUM_W  = 34;
   localparam int DIV_DEN_W  = 24;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
   localparam logic [DIV_DEN_W-1:0] MS_PER_S = 24'd1000;

   // The note length divides by 1000 as a shift by 3 and a multiplication
   // by the rounded-up reciprocal of 125, scaled by 2^38.
   localparam logic [31:0] RECIP_125 = 32'd2199023256;

   localparam logic REQ_NOTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

endpackage

// File: src/sqvs_div.sv
// ----------------------------------------------------------------------------
// sqvs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sqvs_div
   import sqvs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic                 running_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign shifted  = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff     = shifted - {1'b0, den_ff};
   assign fits     = shifted >= {1'b0, den_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            running_ff <= 1'b1;
            count_ff   <= '0;
            rem_ff     <= '0;
            quo_ff     <= dividend;
            den_ff     <= divisor;
         end else if (running_ff) begin
            rem_ff <= fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
            if (count_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

endmodule

// File: src/square_voice_synth_with_slide.sv
// ----------------------------------------------------------------------------
// square_voice_synth_with_slide
// Polyphonic square-wave synthesizer with a linear period slide.
// A tick word steps the live voices and then retires idle voices from the top
// and drives the sample; a note word runs up to four divisions one after
// another on the shared divider.
// One word at a time; busy is high meanwhile. The result strobe is not stalled.
// Reset clears voice lifetimes and the voice count and loads 44100 Hz.
// ----------------------------------------------------------------------------
module square_voice_synth_with_slide
   import sqvs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [15:0]        req_start_hz,
   input  logic [15:0]        req_end_hz,
   input  logic signed [15:0] req_level,
   input  logic [15:0]        req_duration_ms,
   output logic               rsp_strobe,
   output logic signed [19:0] rsp_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [RATE_W-1:0]  csr_sample_rate
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_TTL, S_FULL, S_FTZ, S_PLAN, S_ADJT, S_ADJD, S_TICK, S_TRIM
   } state_type;

   state_type            state_ff;
   logic [RATE_W-1:0]    rate_ff;
   logic [VCNT_W-1:0]    in_use_ff;
   logic [VIDX_W-1:0]    idx_ff;
   logic [VIDX_W-1:0]    voice_ff;
   logic [23:0]          best_ff;
   logic                 wait_ff;
   logic [19:0]          sum_ff;
   logic                 strobe_ff;
   logic [19:0]          sample_ff;

   logic [15:0]          hza_ff;
   logic [15:0]          hzz_ff;
   logic [15:0]          amp_ff;
   logic [33:0]          prod_ff;
   logic [23:0]          ttl_ff;
   logic [17:0]          full_ff;
   logic [17:0]          ftz_ff;
   logic [17:0]          dmag_ff;
   logic                 dneg_ff;
   logic                 long_ff;
   logic [23:0]          adjt_ff;

   logic [23:0] phase_ff    [VOICES];
   logic [24:0] period_ff   [VOICES];
   logic [24:0] half_ff     [VOICES];
   logic [23:0] life_ff     [VOICES];
   logic [15:0] ampl_ff     [VOICES];
   logic [23:0] interval_ff [VOICES];
   logic [24:0] countdown_ff[VOICES];
   logic [24:0] step_ff     [VOICES];

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;

   logic [15:0]          hza_in;
   logic [15:0]          hzz_in;
   logic [15:0]          dur_in;
   logic                 rate_ok;
   logic [62:0]          ttl_prod;
   logic [17:0]          quo_clamp;
   logic signed [18:0]   dtotal;
   logic [18:0]          dabs;
   logic [17:0]          mag_in;
   logic [24:0]          stepv_in;

   logic                 wrapped;
   logic                 low_half;
   logic [19:0]          amp20;
   logic [19:0]          out_in;
   logic [24:0]          cd_dec;
   logic                 reload;
   logic [24:0]          cd_in;
   logic [24:0]          per_in;
   logic [VIDX_W-1:0]    tail_idx;

   sqvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_sample = sample_ff;

   assign hza_in  = (req_start_hz == 16'd0) ? 16'd1 : req_start_hz;
   assign hzz_in  = (req_end_hz == 16'd0) ? 16'd1 : req_end_hz;
   assign dur_in  = (req_duration_ms == 16'd0) ? 16'd1 : req_duration_ms;
   assign rate_ok = (rate_ff >= RATE_MIN) && (rate_ff <= RATE_MAX);

   assign div_start = !wait_ff && ((state_ff == S_FULL) ||
                      (state_ff == S_FTZ) || (state_ff == S_ADJT) ||
                      (state_ff == S_ADJD));

   always_comb begin
      div_num = '0;
      div_den = MS_PER_S;
      case (state_ff)
         S_FULL: begin
            div_num = DIV_NUM_W'(rate_ff);
            div_den = DIV_DEN_W'(hza_ff);
         end
         S_FTZ: begin
            div_num = DIV_NUM_W'(rate_ff);
            div_den = DIV_DEN_W'(hzz_ff);
         end
         S_ADJT: begin
            div_num = DIV_NUM_W'(ttl_ff);
            div_den = DIV_DEN_W'(dmag_ff);
         end
         S_ADJD: begin
            div_num = DIV_NUM_W'(dmag_ff);
            div_den = long_ff ? ttl_ff : adjt_ff;
         end
         default: begin
            div_num = '0;
            div_den = MS_PER_S;
         end
      endcase
   end

   assign ttl_prod  = 63'(prod_ff[33:3]) * 63'(RECIP_125);
   assign quo_clamp = (div_quo < 34'd2) ? 18'd2 : div_quo[17:0];
   assign dtotal    = $signed({1'b0, ftz_ff}) - $signed({1'b0, full_ff});
   assign dabs      = dtotal[18] ? 19'(-dtotal) : 19'(dtotal);
   assign mag_in    = (div_quo[17:0] == 18'd0) ? 18'd1 : div_quo[17:0];
   assign stepv_in  = dneg_ff ? 25'(-{7'd0, mag_in}) : {7'd0, mag_in};

   assign wrapped  = $signed({2'b00, phase_ff[idx_ff]}) >=
                     $signed({period_ff[idx_ff][24], period_ff[idx_ff]});
   assign low_half = $signed({2'b00, phase_ff[idx_ff]}) <
                     $signed({half_ff[idx_ff][24], half_ff[idx_ff]});
   assign amp20    = {{4{ampl_ff[idx_ff][15]}}, ampl_ff[idx_ff]};
   assign out_in   = (wrapped || low_half) ? amp20 : 20'(-amp20);
   assign cd_dec   = countdown_ff[idx_ff] - 25'd1;
   assign reload   = cd_dec[24] || (cd_dec == 25'd0);
   assign cd_in    = cd_dec + {1'b0, interval_ff[idx_ff]};
   assign per_in   = period_ff[idx_ff] + step_ff[idx_ff];
   assign tail_idx = VIDX_W'(in_use_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rate_ff   <= RATE_RESET;
         in_use_ff <= '0;
         idx_ff    <= '0;
         wait_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            life_ff[i] <= '0;
         end
      end else begin
         strobe_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            rate_ff <= csr_sample_rate;
         end
         if (div_start) begin
            wait_ff <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  hza_ff  <= hza_in;
                  hzz_ff  <= hzz_in;
                  amp_ff  <= req_level;
                  prod_ff <= 34'(dur_in) * 34'(rate_ff);
                  idx_ff  <= '0;
                  sum_ff  <= '0;
                  if (req_type == REQ_TICK) begin
                     state_ff <= S_TICK;
                  end else if (rate_ok) begin
                     if (in_use_ff < VCNT_W'(VOICES)) begin
                        voice_ff  <= VIDX_W'(in_use_ff);
                        in_use_ff <= in_use_ff + 1'b1;
                        state_ff  <= S_TTL;
                     end else begin
                        voice_ff <= '0;
                        best_ff  <= life_ff[0];
                        state_ff <= S_SCAN;
                     end
                  end
               end
            end
            S_SCAN: begin
               if (life_ff[idx_ff] == 24'd0) begin
                  voice_ff <= idx_ff;
                  state_ff <= S_TTL;
               end else begin
                  if (life_ff[idx_ff] < best_ff) begin
                     voice_ff <= idx_ff;
                     best_ff  <= life_ff[idx_ff];
                  end
                  if (idx_ff == VIDX_W'(VOICES - 1)) begin
                     state_ff <= S_TTL;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_TTL: begin
               ttl_ff   <= ttl_prod[61:38];
               state_ff <= S_FULL;
            end
            S_FULL: begin
               if (div_done) begin
                  wait_ff                <= 1'b0;
                  full_ff                <= quo_clamp;
                  phase_ff[voice_ff]     <= '0;
                  life_ff[voice_ff]      <= ttl_ff;
                  ampl_ff[voice_ff]      <= amp_ff;
                  period_ff[voice_ff]    <= {7'd0, quo_clamp};
                  half_ff[voice_ff]      <= {8'd0, quo_clamp[17:1]};
                  interval_ff[voice_ff]  <= '0;
                  countdown_ff[voice_ff] <= '0;
                  step_ff[voice_ff]      <= '0;
                  state_ff <= (hza_ff == hzz_ff) ? S_IDLE : S_FTZ;
               end
            end
            S_FTZ: begin
               if (div_done) begin
                  wait_ff  <= 1'b0;
                  ftz_ff   <= quo_clamp;
                  state_ff <= S_PLAN;
               end
            end
            S_PLAN: begin
               dmag_ff <= dabs[17:0];
               dneg_ff <= dtotal[18];
               adjt_ff <= 24'd1;
               if ((dtotal == 19'sd0) || (ttl_ff == 24'd0)) begin
                  state_ff <= S_IDLE;
               end else if ({6'd0, dabs[17:0]} < ttl_ff) begin
                  long_ff  <= 1'b0;
                  state_ff <= S_ADJT;
               end else begin
                  long_ff  <= 1'b1;
                  state_ff <= S_ADJD;
               end
            end
            S_ADJT: begin
               if (div_done) begin
                  wait_ff  <= 1'b0;
                  adjt_ff  <= div_quo[23:0];
                  state_ff <= S_ADJD;
               end
            end
            S_ADJD: begin
               if (div_done) begin
                  wait_ff                <= 1'b0;
                  interval_ff[voice_ff]  <= adjt_ff;
                  countdown_ff[voice_ff] <= {1'b0, adjt_ff};
                  step_ff[voice_ff]      <= stepv_in;
                  state_ff               <= S_IDLE;
               end
            end
            S_TICK: begin
               if (VCNT_W'(idx_ff) >= in_use_ff) begin
                  idx_ff   <= tail_idx;
                  state_ff <= S_TRIM;
               end else begin
                  if (life_ff[idx_ff] != 24'd0) begin
                     sum_ff <= sum_ff + out_in;
                     if (wrapped) begin
                        phase_ff[idx_ff] <= '0;
                     end else begin
                        phase_ff[idx_ff] <= phase_ff[idx_ff] + 24'd1;
                     end
                     if (reload) begin
                        countdown_ff[idx_ff] <= cd_in;
                        period_ff[idx_ff]    <= per_in;
                        half_ff[idx_ff]      <= {per_in[24], per_in[24:1]};
                     end else begin
                        countdown_ff[idx_ff] <= cd_dec;
                     end
                     life_ff[idx_ff] <= life_ff[idx_ff] - 24'd1;
                  end
                  if (idx_ff == VIDX_W'(VOICES - 1)) begin
                     idx_ff   <= tail_idx;
                     state_ff <= S_TRIM;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_TRIM: begin
               if ((in_use_ff != '0) && (life_ff[idx_ff] == 24'd0)) begin
                  in_use_ff <= in_use_ff - 1'b1;
                  idx_ff    <= idx_ff - 1'b1;
               end else begin
                  strobe_ff <= 1'b1;
                  sample_ff <= sum_ff;
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: tb/square_voice_synth_with_slide_test.sv
// ----------------------------------------------------------------------------
// square_voice_synth_with_slide_test
// Self-checking testbench for the square voice synthesizer. A clocked driver
// sends note and tick words from a pending queue with random gaps, and a
// monitor compares each sample strobe against an in-bench voice predictor.
// The run covers several sample rates, including both ends of the legal range
// and values outside it, voice stealing, slides and period overshoot.
// ----------------------------------------------------------------------------
module square_voice_synth_with_slide_test;
   import sqvs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic               kind;
      logic [15:0]        start_hz;
      logic [15:0]        end_hz;
      logic signed [15:0] level;
      logic [15:0]        dur_ms;
   } word_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_type;
   logic [15:0]        req_start_hz;
   logic [15:0]        req_end_hz;
   logic signed [15:0] req_level;
   logic [15:0]        req_duration_ms;
   logic               rsp_strobe;
   logic signed [19:0] rsp_sample;
   logic               csr_valid;
   logic               csr_ready;
   logic [RATE_W-1:0]  csr_sample_rate;

   word_type    pending[$];
   logic [19:0] samples_due[$];
   word_type    held;
   bit          taken;
   int          gap_pct;
   int          errors;
   int          notes_sent;
   int          ticks_sent;
   int          samples_seen;
   int          rates_used;

   // Voice predictor state.
   int unsigned rate;
   int unsigned live_voices;
   int unsigned phase[VOICES];
   int          period[VOICES];
   int          half[VOICES];
   int unsigned ttl[VOICES];
   int          amp[VOICES];
   int          glide_every[VOICES];
   int          glide_left[VOICES];
   int          glide_step[VOICES];

   square_voice_synth_with_slide uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_start_hz(req_start_hz), .req_end_hz(req_end_hz),
      .req_level(req_level), .req_duration_ms(req_duration_ms),
      .rsp_strobe(rsp_strobe), .rsp_sample(rsp_sample),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_sample_rate(csr_sample_rate)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int wrap25(int x);
      logic [24:0] u;
      u = x[24:0];
      return int'($signed(u));
   endfunction

   function automatic void load_voice(word_type w);
      int unsigned hza, hzz, dur, v;
      longint unsigned prod;
      int full, ftz, dtotal, adjt, adjd, life;
      if (rate < RATE_MIN || rate > RATE_MAX) return;
      hza = (w.start_hz == 0) ? 1 : w.start_hz;
      hzz = (w.end_hz == 0) ? 1 : w.end_hz;
      dur = (w.dur_ms == 0) ? 1 : w.dur_ms;
      if (live_voices < VOICES) begin
         v = live_voices;
         live_voices++;
      end else begin
         v = 0;
         for (int i = 0; i < VOICES; i++) begin
            if (ttl[i] == 0) begin
               v = i;
               break;
            end
            if (ttl[i] < ttl[v]) v = i;
         end
      end
      prod = longint'(dur) * rate / 1000;
      full = int'(rate / hza);
      if (full < 2) full = 2;
      phase[v] = 0;
      ttl[v] = 32'(prod);
      amp[v] = w.level;
      period[v] = full;
      half[v] = full >>> 1;
      glide_every[v] = 0;
      glide_left[v] = 0;
      glide_step[v] = 0;
      if (hza == hzz) return;
      ftz = int'(rate / hzz);
      if (ftz < 2) ftz = 2;
      dtotal = ftz - full;
      life = int'(ttl[v]);
      if (dtotal == 0 || life == 0) return;
      if (dtotal > -life && dtotal < life) begin
         adjt = life / dtotal;
         if (adjt == 0) adjt = 1;
         else if (adjt < 0) adjt = -adjt;
         adjd = dtotal / adjt;
      end else begin
         adjt = 1;
         adjd = dtotal / life;
      end
      if (adjd == 0) adjd = (dtotal < 0) ? -1 : 1;
      glide_every[v] = adjt;
      glide_step[v] = adjd;
      glide_left[v] = adjt;
   endfunction

   function automatic logic [19:0] mix_voices();
      int sum;
      int out;
      sum = 0;
      for (int v = 0; v < VOICES; v++) begin
         if (v >= live_voices || ttl[v] == 0) continue;
         if (int'(phase[v]) >= period[v]) begin
            phase[v] = 0;
            out = amp[v];
         end else begin
            out = (int'(phase[v]) >= half[v]) ? -amp[v] : amp[v];
            phase[v] = (phase[v] + 1) & 24'hFFFFFF;
         end
         glide_left[v] = wrap25(glide_left[v] - 1);
         if (glide_left[v] <= 0) begin
            glide_left[v] = wrap25(glide_left[v] + glide_every[v]);
            period[v] = wrap25(period[v] + glide_step[v]);
            half[v] = period[v] >>> 1;
         end
         ttl[v]--;
         sum += out;
      end
      while (live_voices > 0 && ttl[live_voices-1] == 0) live_voices--;
      return sum[19:0];
   endfunction

   function automatic logic [15:0] pick_hz();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 16'($urandom_range(4000, 20));
      if (r < 75) return 16'($urandom_range(3));
      return 16'($urandom);
   endfunction

   function automatic word_type random_word();
      word_type w;
      int r;
      w.kind = ($urandom_range(99) < 27) ? REQ_NOTE : REQ_TICK;
      w.start_hz = pick_hz();
      w.end_hz = ($urandom_range(99) < 30) ? w.start_hz : pick_hz();
      w.level = 16'($urandom);
      r = $urandom_range(99);
      if (r < 70) w.dur_ms = 16'($urandom_range(30, 1));
      else if (r < 90) w.dur_ms = 16'($urandom_range(3));
      else w.dur_ms = 16'($urandom);
      return w;
   endfunction

   function automatic word_type note(int a, int z, int lvl, int d);
      word_type w;
      w.kind = REQ_NOTE;
      w.start_hz = 16'(a);
      w.end_hz = 16'(z);
      w.level = 16'(lvl);
      w.dur_ms = 16'(d);
      return w;
   endfunction

   function automatic word_type tick();
      word_type w;
      w = note(0, 0, 0, 0);
      w.kind = REQ_TICK;
      w.start_hz = 16'($urandom);
      w.end_hz = 16'($urandom);
      w.level = 16'($urandom);
      w.dur_ms = 16'($urandom);
      return w;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_type <= REQ_TICK;
         req_start_hz <= '0;
         req_end_hz <= '0;
         req_level <= '0;
         req_duration_ms <= '0;
      end else if (!start || taken) begin
         taken = 1'b0;
         if (pending.size() > 0 && $urandom_range(99) >= gap_pct) begin
            held = pending.pop_front();
            start <= 1'b1;
            req_type <= held.kind;
            req_start_hz <= held.start_hz;
            req_end_hz <= held.end_hz;
            req_level <= held.level;
            req_duration_ms <= held.dur_ms;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic [19:0] want;
      if (!reset && rsp_strobe) begin
         samples_seen++;
         if (samples_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected sample word %0d", rsp_sample);
         end else begin
            want = samples_due.pop_front();
            if (rsp_sample !== want) begin
               errors++;
               if (errors <= 10)
                  $display("Sample mismatch: expected %0d, got %0d",
                           $signed(want), rsp_sample);
            end
         end
      end
      if (!reset && start && !busy) begin
         taken = 1'b1;
         if (held.kind == REQ_NOTE) begin
            notes_sent++;
            load_voice(held);
         end else begin
            ticks_sent++;
            samples_due.push_back(mix_voices());
         end
      end
   end

   task automatic drain();
      do @(posedge clock);
      while (pending.size() > 0 || start || samples_due.size() > 0);
      repeat (300) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_rate(int unsigned r);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_sample_rate <= RATE_W'(r);
      do @(posedge clock);
      while (!csr_ready);
      rate = r;
      rates_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned rate_plan[6];
      int unsigned pct_plan[6];
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_sample_rate = '0;
      taken = 1'b0;
      gap_pct = 0;
      errors = 0;
      rate = RATE_RESET;
      live_voices = 0;
      for (int v = 0; v < VOICES; v++) ttl[v] = 0;
      rate_plan = '{44100, 200, 200000, 199, 262143, 48000};
      pct_plan = '{38, 38, 55, 55, 0, 0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words at the reset rate.
      pending.push_back(tick());
      pending.push_back(note(0, 0, 32767, 0));
      pending.push_back(note(65535, 1, -32768, 65535));
      pending.push_back(note(44100, 44099, 1000, 10));
      pending.push_back(note(440, 880, -1, 5));
      pending.push_back(note(1000, 20, 12345, 1));
      pending.push_back(tick());
      pending.push_back(tick());
      pending.push_back(note(300, 60000, 20000, 2));
      pending.push_back(note(50, 50, -20000, 3));
      pending.push_back(note(100, 200, 16384, 4));
      pending.push_back(note(7, 65535, 32767, 20));
      pending.push_back(note(2000, 2000, 32767, 0));
      for (int i = 0; i < 12; i++) pending.push_back(tick());
      drain();

      for (int p = 0; p < 6; p++) begin
         write_rate(rate_plan[p]);
         gap_pct = pct_plan[p];
         for (int i = 0; i < 140; i++) pending.push_back(random_word());
         drain();
      end

      $display("Sent %0d note words and %0d tick words, checked %0d samples over %0d rates.",
               notes_sent, ticks_sent, samples_seen, rates_used);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
